[hw/rtl/canonical_cbor_item_stream_parser_assert.svh]
// Assertion macros shared by the parser RTL.
// Each macro takes a label, a clock, an active-low reset, a trigger and a consequence.
`ifndef CANONICAL_CBOR_ITEM_STREAM_PARSER_ASSERT_SVH
`define CANONICAL_CBOR_ITEM_STREAM_PARSER_ASSERT_SVH

// The consequence must hold in the same cycle as the trigger.
`define CCISP_ASSERT_SAME(label, clk_s, rst_s, trig, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (trig) |-> (cons)) \
        else $error("parser check failed");

// The consequence must hold in the cycle after the trigger.
`define CCISP_ASSERT_NEXT(label, clk_s, rst_s, trig, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (trig) |=> (cons)) \
        else $error("parser check failed");

`endif

[hw/rtl/ccisp_pkg.sv]
package ccisp_pkg;

    // Result kinds.
    typedef enum logic [3:0] {
        KIND_NULL       = 4'd0,
        KIND_TRUE       = 4'd1,
        KIND_FALSE      = 4'd2,
        KIND_FLOAT      = 4'd3,
        KIND_BYTES_HEAD = 4'd4,
        KIND_TEXT_HEAD  = 4'd5,
        KIND_ARRAY_HEAD = 4'd6,
        KIND_MAP_HEAD   = 4'd7,
        KIND_PAYLOAD    = 4'd8
    } kind_t;

    // Error codes.
    typedef enum logic [2:0] {
        ERR_NONE  = 3'd0,
        ERR_EOF   = 3'd1,
        ERR_CANON = 3'd2,
        ERR_TAG   = 3'd3,
        ERR_NAN   = 3'd4,
        ERR_UTF8  = 3'd5
    } err_t;

    // Major types that carry a length.
    localparam logic [2:0] MAJOR_BYTES = 3'd2;
    localparam logic [2:0] MAJOR_TEXT  = 3'd3;
    localparam logic [2:0] MAJOR_ARRAY = 3'd4;
    localparam logic [2:0] MAJOR_MAP   = 3'd5;

    // Special head bytes.
    localparam logic [7:0] BYTE_NULL  = 8'hF6;
    localparam logic [7:0] BYTE_TRUE  = 8'hF5;
    localparam logic [7:0] BYTE_FALSE = 8'hF4;
    localparam logic [7:0] BYTE_FLOAT = 8'hFB;

    // Additional information thresholds.
    localparam logic [4:0] ADD_RESERVED_MIN = 5'd28;
    localparam logic [4:0] ADD_FOLLOW_MIN   = 5'd24;

    // Limits for shortest-form arguments.
    localparam logic [63:0] ARG1_MIN_VALID = 64'd23;
    localparam logic [3:0]  FLOAT_BYTES    = 4'd8;
    localparam logic [63:0] CANON_NAN      = 64'h7ff8_0000_0000_0000;

    // UTF-8 states.
    localparam logic [3:0] UTF8_START  = 4'd0;
    localparam logic [3:0] UTF8_DEAD   = 4'd1;
    localparam logic [3:0] UTF8_STATES = 4'd9;

    // UTF-8 transitions, sixteen classes for each state.
    localparam logic [3:0] UTF8_TRANS [0:143] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1,
        4'd1, 4'd1, 4'd4, 4'd6, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0,
        4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
        4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
        4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
        4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1
    };

    // Byte class of the UTF-8 automaton.
    function automatic logic [3:0] utf8_class(input logic [7:0] b);
        logic [3:0] cls;
        priority if (b < 8'h80) cls = 4'd0;
        else if (b < 8'h90) cls = 4'd1;
        else if (b < 8'hA0) cls = 4'd9;
        else if (b < 8'hC0) cls = 4'd7;
        else if (b < 8'hC2) cls = 4'd8;
        else if (b < 8'hE0) cls = 4'd2;
        else if (b == 8'hE0) cls = 4'd10;
        else if (b == 8'hED) cls = 4'd4;
        else if (b < 8'hF0) cls = 4'd3;
        else if (b == 8'hF0) cls = 4'd11;
        else if (b < 8'hF4) cls = 4'd6;
        else if (b == 8'hF4) cls = 4'd5;
        else cls = 4'd8;
        return cls;
    endfunction

    // One step of the UTF-8 automaton; unknown states reject.
    function automatic logic [3:0] utf8_next(input logic [3:0] st, input logic [7:0] b);
        logic [3:0] nxt;
        if (st >= UTF8_STATES) nxt = UTF8_DEAD;
        else nxt = UTF8_TRANS[{st, utf8_class(b)}];
        return nxt;
    endfunction

    // Result of one decoding step.
    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [63:0] value;
        logic        string_end;
        err_t        error_code;
    } result_t;

endpackage

[hw/rtl/canonical_cbor_item_stream_parser.sv]
// Channel  Direction  Handshake             Payload
// input    in         in_valid / in_stall   data_byte, end_of_input
// output   out        out_valid / out_stall kind, value, string_end, error_code
//
// One byte is accepted per cycle while in_stall is low; it is held in the input
// register, its result is registered in the result register, and the word then
// leaves from the result register.
// Reset (rst_n low) clears the decoder to the head state and empties both registers.
// out_stall holds the result register; the input register then holds its byte
// and in_stall rises, so throughput follows the output side.
// A byte that gives no result still steps the decoder.
`include "canonical_cbor_item_stream_parser_assert.svh"

module canonical_cbor_item_stream_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  kind,
    output logic [63:0] value,
    output logic        string_end,
    output logic [2:0]  error_code
);

    logic               in_valid_reg, in_valid_next;
    logic [7:0]         byte_reg;
    logic               eoi_reg;
    logic               out_valid_reg, out_valid_next;
    logic [3:0]         kind_reg;
    logic [63:0]        value_reg;
    logic               string_end_reg;
    logic [2:0]         error_code_reg;
    logic               step;
    logic               in_take;
    ccisp_pkg::result_t result;

    // The held word moves on whenever the result register is free or draining.
    assign step     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !step;
    assign in_take  = in_valid && !in_stall;

    assign in_valid_next  = in_take || (in_valid_reg && !step);
    assign out_valid_next = step ? result.valid : (out_valid_reg && out_stall);

    ccisp_decode u_decode
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .data_byte    (byte_reg),
        .end_of_input (eoi_reg),
        .result       (result)
    );

    // Valid flags of the input and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload of the input and result registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= data_byte;
            eoi_reg  <= end_of_input;
        end
        if (step && result.valid)
        begin
            kind_reg       <= result.kind;
            value_reg      <= result.value;
            string_end_reg <= result.string_end;
            error_code_reg <= result.error_code;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign value      = value_reg;
    assign string_end = string_end_reg;
    assign error_code = error_code_reg;

    // Input back-pressure only comes from a stalled result.
    `CCISP_ASSERT_SAME(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)
    // An error word carries nothing but its code.
    `CCISP_ASSERT_SAME(a_error_clean, clk, rst_n, out_valid && error_code != ccisp_pkg::ERR_NONE,
                       kind == ccisp_pkg::KIND_NULL && value == 64'd0 && !string_end)
    // String end only marks payload bytes or string heads.
    `CCISP_ASSERT_SAME(a_end_kind, clk, rst_n, out_valid && string_end,
                       kind == ccisp_pkg::KIND_PAYLOAD || kind == ccisp_pkg::KIND_BYTES_HEAD
                       || kind == ccisp_pkg::KIND_TEXT_HEAD)
    // No result appears when nothing was held and nothing was shown.
    `CCISP_ASSERT_NEXT(a_no_spurious, clk, rst_n, !out_valid && !in_valid_reg, !out_valid)

endmodule

[hw/rtl/ccisp_decode.sv]
// Decoder state and the logic that moves it on by one byte.
module ccisp_decode
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          data_byte,
    input  logic                end_of_input,
    output ccisp_pkg::result_t  result
);

    typedef enum logic [1:0] {
        PH_HEAD    = 2'd0,
        PH_ARG     = 2'd1,
        PH_FLOAT   = 2'd2,
        PH_PAYLOAD = 2'd3
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  left_reg, left_next;
    logic [63:0] acc_reg, acc_next;
    logic [2:0]  major_reg, major_next;
    logic [63:0] remain_reg, remain_next;
    logic [3:0]  utf8_reg, utf8_next_s;
    logic        stopped_reg, stopped_next;
    logic [1:0]  width_reg, width_next;

    logic [63:0]       acc_shift;
    logic [3:0]        left_dec;
    logic [63:0]       remain_dec;
    logic [3:0]        utf8_stepped;
    logic              canon_ok;
    logic              nan_bad;
    logic              hd_done;
    logic [2:0]        hd_major;
    logic [63:0]       hd_arg;
    logic              have;
    ccisp_pkg::kind_t  kind;
    logic [63:0]       value;
    logic              send;
    ccisp_pkg::err_t   err;

    // Shared datapath terms.
    assign acc_shift    = {acc_reg[55:0], data_byte};
    assign left_dec     = (left_reg != 4'd0) ? left_reg - 4'd1 : 4'd0;
    assign remain_dec   = (remain_reg != 64'd0) ? remain_reg - 64'd1 : 64'd0;
    assign utf8_stepped = ccisp_pkg::utf8_next(utf8_reg, data_byte);
    assign nan_bad      = (&acc_shift[62:52]) && (|acc_shift[51:0])
                          && (acc_shift != ccisp_pkg::CANON_NAN);

    // Shortest-form check on a completed argument.
    always_comb
    begin
        unique case (width_reg)
            2'd0: canon_ok = acc_shift > ccisp_pkg::ARG1_MIN_VALID;
            2'd1: canon_ok = |acc_shift[63:8];
            2'd2: canon_ok = |acc_shift[63:16];
            2'd3: canon_ok = |acc_shift[63:32];
            default: canon_ok = 1'b0;
        endcase
    end

    // Next state and result for the byte in hand.
    always_comb
    begin
        phase_next   = phase_reg;
        left_next    = left_reg;
        acc_next     = acc_reg;
        major_next   = major_reg;
        remain_next  = remain_reg;
        utf8_next_s  = utf8_reg;
        stopped_next = stopped_reg;
        width_next   = width_reg;
        have         = 1'b0;
        kind         = ccisp_pkg::KIND_NULL;
        value        = 64'd0;
        send         = 1'b0;
        err          = ccisp_pkg::ERR_NONE;
        hd_done      = 1'b0;
        hd_major     = 3'd0;
        hd_arg       = 64'd0;

        if (!stopped_reg)
        begin
            unique case (phase_reg)
                PH_HEAD:
                begin
                    priority if (data_byte == ccisp_pkg::BYTE_NULL)
                    begin
                        have = 1'b1;
                        kind = ccisp_pkg::KIND_NULL;
                    end
                    else if (data_byte == ccisp_pkg::BYTE_TRUE)
                    begin
                        have = 1'b1;
                        kind = ccisp_pkg::KIND_TRUE;
                    end
                    else if (data_byte == ccisp_pkg::BYTE_FALSE)
                    begin
                        have = 1'b1;
                        kind = ccisp_pkg::KIND_FALSE;
                    end
                    else if (data_byte == ccisp_pkg::BYTE_FLOAT)
                    begin
                        phase_next = PH_FLOAT;
                        left_next  = ccisp_pkg::FLOAT_BYTES;
                        acc_next   = 64'd0;
                    end
                    else if (data_byte[4:0] >= ccisp_pkg::ADD_RESERVED_MIN)
                    begin
                        err = ccisp_pkg::ERR_TAG;
                    end
                    else if (data_byte[4:0] >= ccisp_pkg::ADD_FOLLOW_MIN)
                    begin
                        phase_next = PH_ARG;
                        left_next  = 4'd1 << data_byte[1:0];
                        width_next = data_byte[1:0];
                        acc_next   = 64'd0;
                        major_next = data_byte[7:5];
                    end
                    else
                    begin
                        hd_done  = 1'b1;
                        hd_major = data_byte[7:5];
                        hd_arg   = {59'd0, data_byte[4:0]};
                    end
                end
                PH_ARG, PH_FLOAT:
                begin
                    acc_next  = acc_shift;
                    left_next = left_dec;
                    if (left_dec == 4'd0)
                    begin
                        phase_next = PH_HEAD;
                        if (phase_reg == PH_FLOAT)
                        begin
                            if (nan_bad)
                            begin
                                err = ccisp_pkg::ERR_NAN;
                            end
                            else
                            begin
                                have  = 1'b1;
                                kind  = ccisp_pkg::KIND_FLOAT;
                                value = acc_shift;
                            end
                        end
                        else if (!canon_ok)
                        begin
                            err = ccisp_pkg::ERR_CANON;
                        end
                        else
                        begin
                            hd_done  = 1'b1;
                            hd_major = major_reg;
                            hd_arg   = acc_shift;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    if (major_reg == ccisp_pkg::MAJOR_TEXT)
                    begin
                        utf8_next_s = utf8_stepped;
                    end
                    remain_next = remain_dec;
                    if (remain_dec == 64'd0)
                    begin
                        phase_next = PH_HEAD;
                        if (major_reg == ccisp_pkg::MAJOR_TEXT
                            && utf8_stepped != ccisp_pkg::UTF8_START)
                        begin
                            err = ccisp_pkg::ERR_UTF8;
                        end
                        else
                        begin
                            have  = 1'b1;
                            kind  = ccisp_pkg::KIND_PAYLOAD;
                            value = {56'd0, data_byte};
                            send  = 1'b1;
                        end
                    end
                    else
                    begin
                        have  = 1'b1;
                        kind  = ccisp_pkg::KIND_PAYLOAD;
                        value = {56'd0, data_byte};
                    end
                end
                default:
                begin
                    phase_next = PH_HEAD;
                end
            endcase

            // A complete head: only strings, arrays and maps are accepted.
            if (hd_done)
            begin
                phase_next = PH_HEAD;
                if (hd_major < ccisp_pkg::MAJOR_BYTES || hd_major > ccisp_pkg::MAJOR_MAP)
                begin
                    err = ccisp_pkg::ERR_TAG;
                end
                else
                begin
                    have  = 1'b1;
                    kind  = ccisp_pkg::kind_t'({1'b0, hd_major} + 4'd2);
                    value = hd_arg;
                    if (hd_major == ccisp_pkg::MAJOR_BYTES || hd_major == ccisp_pkg::MAJOR_TEXT)
                    begin
                        if (hd_arg == 64'd0)
                        begin
                            send = 1'b1;
                        end
                        else
                        begin
                            phase_next  = PH_PAYLOAD;
                            remain_next = hd_arg;
                            major_next  = hd_major;
                            utf8_next_s = ccisp_pkg::UTF8_START;
                        end
                    end
                end
            end

            // The buffer ends with an item still open.
            if (err == ccisp_pkg::ERR_NONE && end_of_input && phase_next != PH_HEAD)
            begin
                err  = ccisp_pkg::ERR_EOF;
                have = 1'b0;
            end

            if (err != ccisp_pkg::ERR_NONE && !end_of_input)
            begin
                stopped_next = 1'b1;
            end
        end

        // End of input always starts a fresh buffer.
        if (end_of_input)
        begin
            phase_next   = PH_HEAD;
            left_next    = 4'd0;
            acc_next     = 64'd0;
            major_next   = 3'd0;
            remain_next  = 64'd0;
            utf8_next_s  = ccisp_pkg::UTF8_START;
            stopped_next = 1'b0;
            width_next   = 2'd0;
        end

        // An error word carries only its code.
        result.valid      = have || (err != ccisp_pkg::ERR_NONE);
        result.error_code = err;
        if (err != ccisp_pkg::ERR_NONE)
        begin
            result.kind       = ccisp_pkg::KIND_NULL;
            result.value      = 64'd0;
            result.string_end = 1'b0;
        end
        else
        begin
            result.kind       = kind;
            result.value      = value;
            result.string_end = send;
        end
    end

    // Decoder state, moved on once per processed byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEAD;
            left_reg    <= 4'd0;
            acc_reg     <= 64'd0;
            major_reg   <= 3'd0;
            remain_reg  <= 64'd0;
            utf8_reg    <= ccisp_pkg::UTF8_START;
            stopped_reg <= 1'b0;
            width_reg   <= 2'd0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            left_reg    <= left_next;
            acc_reg     <= acc_next;
            major_reg   <= major_next;
            remain_reg  <= remain_next;
            utf8_reg    <= utf8_next_s;
            stopped_reg <= stopped_next;
            width_reg   <= width_next;
        end
    end

endmodule

[dv/testbench.sv]
module testbench;
    import ccisp_pkg::*;

    // One decoded word as it leaves the parser.
    typedef struct packed {
        kind_t       kind;
        logic [63:0] value;
        logic        send;
        err_t        err;
    } cbor_word_t;

    // One row of the directed script: a byte, and optionally the word it must give.
    typedef struct packed {
        logic [7:0] b;
        logic       eoi;
        logic       typed;
        logic       gives;
        cbor_word_t w;
    } probe_t;

    // Decoder phases of the predictor.
    typedef enum logic [1:0] {AWAIT_HEAD, IN_ARG, IN_FLOAT, IN_PAYLOAD} walk_t;

    // UTF-8 automaton states beyond accept and reject.
    localparam logic [3:0] U8_NEED1 = 4'd2;
    localparam logic [3:0] U8_NEED2 = 4'd3;
    localparam logic [3:0] U8_AFTER_E0 = 4'd4;
    localparam logic [3:0] U8_AFTER_ED = 4'd5;
    localparam logic [3:0] U8_AFTER_F0 = 4'd6;
    localparam logic [3:0] U8_NEED3 = 4'd7;
    localparam logic [3:0] U8_AFTER_F4 = 4'd8;

    localparam cbor_word_t W_NONE  = '{KIND_NULL, 64'd0, 1'b0, ERR_NONE};
    localparam cbor_word_t W_NULL  = '{KIND_NULL, 64'd0, 1'b0, ERR_NONE};
    localparam cbor_word_t W_TRUE  = '{KIND_TRUE, 64'd0, 1'b0, ERR_NONE};
    localparam cbor_word_t W_FALSE = '{KIND_FALSE, 64'd0, 1'b0, ERR_NONE};
    localparam cbor_word_t W_TEXT0 = '{KIND_TEXT_HEAD, 64'd0, 1'b1, ERR_NONE};
    localparam cbor_word_t W_TAG   = '{KIND_NULL, 64'd0, 1'b0, ERR_TAG};
    localparam cbor_word_t W_CANON = '{KIND_NULL, 64'd0, 1'b0, ERR_CANON};
    localparam cbor_word_t W_NAN   = '{KIND_NULL, 64'd0, 1'b0, ERR_NAN};
    localparam cbor_word_t W_UTF8  = '{KIND_NULL, 64'd0, 1'b0, ERR_UTF8};
    localparam cbor_word_t W_EOF   = '{KIND_NULL, 64'd0, 1'b0, ERR_EOF};

    localparam int SCRIPT_LEN = 27;

    // Directed script: simple values, reserved additional info, short-form
    // violation, negative NaN, bad UTF-8, end of input inside a head, and a
    // one-byte string that ends the buffer.
    localparam probe_t SCRIPT [0:SCRIPT_LEN-1] = '{
        '{8'hF6, 1'b0, 1'b1, 1'b1, W_NULL},
        '{8'hF5, 1'b0, 1'b1, 1'b1, W_TRUE},
        '{8'hF4, 1'b0, 1'b1, 1'b1, W_FALSE},
        '{8'h5F, 1'b0, 1'b1, 1'b1, W_TAG},
        '{8'hAA, 1'b1, 1'b1, 1'b0, W_NONE},
        '{8'h18, 1'b0, 1'b0, 1'b0, W_NONE},
        '{8'h17, 1'b0, 1'b1, 1'b1, W_CANON},
        '{8'h00, 1'b1, 1'b1, 1'b0, W_NONE},
        '{8'hFB, 1'b0, 1'b0, 1'b0, W_NONE},
        '{8'hFF, 1'b0, 1'b0, 1'b0, W_NONE},
        '{8'hF0, 1'b0, 1'b0, 1'b0, W_NONE},
        '{8'h00, 1'b0, 1'b0, 1'b0, W_NONE},
        '{8'h00, 1'b0, 1'b0, 1'b0, W_NONE},
        '{8'h00, 1'b0, 1'b0, 1'b0, W_NONE},
        '{8'h00, 1'b0, 1'b0, 1'b0, W_NONE},
        '{8'h00, 1'b0, 1'b0, 1'b0, W_NONE},
        '{8'h01, 1'b0, 1'b1, 1'b1, W_NAN},
        '{8'hFF, 1'b1, 1'b1, 1'b0, W_NONE},
        '{8'h60, 1'b0, 1'b1, 1'b1, W_TEXT0},
        '{8'h62, 1'b0, 1'b0, 1'b0, W_NONE},
        '{8'hC3, 1'b0, 1'b0, 1'b0, W_NONE},
        '{8'h28, 1'b0, 1'b1, 1'b1, W_UTF8},
        '{8'h00, 1'b1, 1'b1, 1'b0, W_NONE},
        '{8'h7A, 1'b1, 1'b1, 1'b1, W_EOF},
        '{8'h41, 1'b0, 1'b0, 1'b0, W_NONE},
        '{8'hFF, 1'b1, 1'b0, 1'b0, W_NONE},
        '{8'h00, 1'b1, 1'b1, 1'b1, W_TAG}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'd0;
    logic        end_of_input = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  kind;
    logic [63:0] value;
    logic        string_end;
    logic [2:0]  error_code;

    // Typed expectation travelling with the word on the input side.
    logic        typed_on = 1'b0;
    logic        typed_gives = 1'b0;
    cbor_word_t  typed_word = '{KIND_NULL, 64'd0, 1'b0, ERR_NONE};

    cbor_word_t  decoded_items [$];
    logic [7:0]  burst [$];
    logic [7:0]  glyphs [$];
    int          faults = 0;
    int          live_words = 0;
    bit          calm = 1'b0;

    // Predictor state.
    walk_t       walk = AWAIT_HEAD;
    logic [3:0]  head_left = 4'd0;
    logic [63:0] acc = 64'd0;
    logic [2:0]  major_held = 3'd0;
    logic [63:0] pay_left = 64'd0;
    logic [3:0]  u8 = UTF8_START;
    bit          halted = 1'b0;
    logic [3:0]  arg_w = 4'd0;

    canonical_cbor_item_stream_parser u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .value        (value),
        .string_end   (string_end),
        .error_code   (error_code)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Back to the state of a fresh buffer.
    function automatic void clear_decoder();
        walk = AWAIT_HEAD;
        head_left = 4'd0;
        acc = 64'd0;
        major_held = 3'd0;
        pay_left = 64'd0;
        u8 = UTF8_START;
        halted = 1'b0;
        arg_w = 4'd0;
    endfunction

    // One step of the UTF-8 validator, written on byte ranges.
    function automatic logic [3:0] utf8_step(input logic [3:0] st, input logic [7:0] b);
        logic c_lo;
        logic c_mid;
        logic c_hi;
        logic [3:0] nxt;
        c_lo = (b >= 8'h80) && (b <= 8'h8F);
        c_mid = (b >= 8'h90) && (b <= 8'h9F);
        c_hi = (b >= 8'hA0) && (b <= 8'hBF);
        nxt = UTF8_DEAD;
        case (st)
            UTF8_START:
            begin
                if (b < 8'h80) nxt = UTF8_START;
                else if (b >= 8'hC2 && b <= 8'hDF) nxt = U8_NEED1;
                else if (b == 8'hE0) nxt = U8_AFTER_E0;
                else if (b == 8'hED) nxt = U8_AFTER_ED;
                else if (b >= 8'hE1 && b <= 8'hEF) nxt = U8_NEED2;
                else if (b == 8'hF0) nxt = U8_AFTER_F0;
                else if (b >= 8'hF1 && b <= 8'hF3) nxt = U8_NEED3;
                else if (b == 8'hF4) nxt = U8_AFTER_F4;
            end
            U8_NEED1:    if (c_lo || c_mid || c_hi) nxt = UTF8_START;
            U8_NEED2:    if (c_lo || c_mid || c_hi) nxt = U8_NEED1;
            U8_AFTER_E0: if (c_hi) nxt = U8_NEED1;
            U8_AFTER_ED: if (c_lo || c_mid) nxt = U8_NEED1;
            U8_AFTER_F0: if (c_mid || c_hi) nxt = U8_NEED2;
            U8_NEED3:    if (c_lo || c_mid || c_hi) nxt = U8_NEED2;
            U8_AFTER_F4: if (c_lo) nxt = U8_NEED2;
            default:     nxt = UTF8_DEAD;
        endcase
        return nxt;
    endfunction

    // A head is complete: only string, array and map heads are allowed.
    function automatic err_t head_done(input logic [2:0] major, input logic [63:0] arg,
                                       output kind_t k, output logic s);
        k = KIND_NULL;
        s = 1'b0;
        walk = AWAIT_HEAD;
        if (major < MAJOR_BYTES || major > MAJOR_MAP)
            return ERR_TAG;
        k = kind_t'({1'b0, major} + 4'd2);
        if (major == MAJOR_BYTES || major == MAJOR_TEXT)
        begin
            if (arg == 64'd0)
                s = 1'b1;
            else
            begin
                walk = IN_PAYLOAD;
                pay_left = arg;
                major_held = major;
                u8 = UTF8_START;
            end
        end
        return ERR_NONE;
    endfunction

    // Decode one accepted byte; returns 1 when it gives a word.
    function automatic bit decode_byte(input logic [7:0] b, input logic eoi,
                                       output cbor_word_t w);
        err_t        e;
        bit          have;
        kind_t       k;
        logic [63:0] v;
        logic        s;
        logic [2:0]  major;
        logic [4:0]  add;
        logic [63:0] lim;
        e = ERR_NONE;
        have = 1'b0;
        k = KIND_NULL;
        v = 64'd0;
        s = 1'b0;
        w = W_NONE;
        if (halted)
        begin
            if (eoi)
                clear_decoder();
            return 1'b0;
        end
        case (walk)
            AWAIT_HEAD:
            begin
                major = b[7:5];
                add = b[4:0];
                if (b == BYTE_NULL) begin have = 1'b1; k = KIND_NULL; end
                else if (b == BYTE_TRUE) begin have = 1'b1; k = KIND_TRUE; end
                else if (b == BYTE_FALSE) begin have = 1'b1; k = KIND_FALSE; end
                else if (b == BYTE_FLOAT)
                begin
                    walk = IN_FLOAT;
                    head_left = 4'd8;
                    acc = 64'd0;
                end
                else if (add >= 5'd28)
                    e = ERR_TAG;
                else if (add >= 5'd24)
                begin
                    arg_w = 4'd1 << (add - 5'd24);
                    walk = IN_ARG;
                    head_left = arg_w;
                    acc = 64'd0;
                    major_held = major;
                end
                else
                begin
                    e = head_done(major, {59'd0, add}, k, s);
                    if (e == ERR_NONE)
                    begin
                        have = 1'b1;
                        v = {59'd0, add};
                    end
                end
            end
            IN_ARG, IN_FLOAT:
            begin
                acc = {acc[55:0], b};
                if (head_left != 4'd0)
                    head_left = head_left - 4'd1;
                if (head_left == 4'd0)
                begin
                    if (walk == IN_FLOAT)
                    begin
                        walk = AWAIT_HEAD;
                        if (acc[62:52] == 11'h7FF && acc[51:0] != 52'd0 && acc != CANON_NAN)
                            e = ERR_NAN;
                        else
                        begin
                            have = 1'b1;
                            k = KIND_FLOAT;
                            v = acc;
                        end
                    end
                    else
                    begin
                        // Shortest form: the argument must not fit a narrower encoding.
                        case (arg_w)
                            4'd1: lim = 64'd23;
                            4'd2: lim = 64'd255;
                            4'd4: lim = 64'd65535;
                            default: lim = 64'hFFFF_FFFF;
                        endcase
                        if (acc <= lim)
                        begin
                            walk = AWAIT_HEAD;
                            e = ERR_CANON;
                        end
                        else
                        begin
                            e = head_done(major_held, acc, k, s);
                            if (e == ERR_NONE)
                            begin
                                have = 1'b1;
                                v = acc;
                            end
                        end
                    end
                end
            end
            default:
            begin
                if (major_held == MAJOR_TEXT)
                    u8 = utf8_step(u8, b);
                if (pay_left != 64'd0)
                    pay_left = pay_left - 64'd1;
                have = 1'b1;
                k = KIND_PAYLOAD;
                v = {56'd0, b};
                if (pay_left == 64'd0)
                begin
                    walk = AWAIT_HEAD;
                    s = 1'b1;
                    if (major_held == MAJOR_TEXT && u8 != UTF8_START)
                    begin
                        e = ERR_UTF8;
                        have = 1'b0;
                    end
                end
            end
        endcase
        // End of input inside an unfinished item wins over its normal word.
        if (e == ERR_NONE && eoi && walk != AWAIT_HEAD)
        begin
            e = ERR_EOF;
            have = 1'b0;
        end
        if (e != ERR_NONE)
        begin
            w.err = e;
            if (eoi)
                clear_decoder();
            else
                halted = 1'b1;
            return 1'b1;
        end
        if (eoi)
            clear_decoder();
        if (!have)
            return 1'b0;
        w.kind = k;
        w.value = v;
        w.send = s;
        return 1'b1;
    endfunction

    function automatic void report(input string field, input logic [63:0] want_v,
                                   input logic [63:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want_v, got_v);
            faults++;
        end
    endfunction

    // Check each word that leaves, then predict from each word that enters.
    always @(posedge clk)
    begin : watch
        cbor_word_t want;
        cbor_word_t got;
        bit gives;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (decoded_items.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, got kind %0d value %0h err %0d",
                             $time, kind, value, error_code);
                    faults++;
                end
                else
                begin
                    want = decoded_items.pop_front();
                    report("kind", 64'(want.kind), 64'(kind));
                    report("value", want.value, value);
                    report("string_end", 64'(want.send), 64'(string_end));
                    report("error_code", 64'(want.err), 64'(error_code));
                end
            end
            if (in_valid && !in_stall)
            begin
                live_words++;
                gives = decode_byte(data_byte, end_of_input, got);
                if (typed_on)
                begin
                    if (typed_gives)
                        decoded_items.push_back(typed_word);
                end
                else if (gives)
                    decoded_items.push_back(got);
            end
        end
    end

    // Receiving side: a random stall before each word, none in calm stretches.
    initial
    begin : receiver
        int gap;
        forever
        begin
            gap = calm ? 0 : $urandom_range(0, 10);
            repeat (gap)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Offer one word after a random gap and hold it until it is taken.
    task automatic put_word(input logic [7:0] b, input logic eoi, input logic typed,
                            input logic gives, input cbor_word_t w);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        data_byte <= b;
        end_of_input <= eoi;
        typed_on <= typed;
        typed_gives <= gives;
        typed_word <= w;
        do @(posedge clk); while (in_stall);
    endtask

    // Hold the input back until every predicted word has left.
    task automatic drain_decoder();
        @(negedge clk);
        in_valid <= 1'b0;
        while (decoded_items.size() != 0)
            @(posedge clk);
    endtask

    // Length head of a given major type, optionally in a wider form than needed.
    task automatic push_head(input logic [2:0] major, input logic [63:0] len, input bit skew);
        int wsel;
        int n;
        if (len < 64'd24) wsel = 0;
        else if (len < 64'd256) wsel = 1;
        else if (len < 64'd65536) wsel = 2;
        else if (len < 64'h1_0000_0000) wsel = 3;
        else wsel = 4;
        if (skew && wsel < 4)
            wsel = $urandom_range(wsel + 1, 4);
        if (wsel == 0)
            burst.push_back({major, len[4:0]});
        else
        begin
            n = 1 << (wsel - 1);
            burst.push_back({major, 5'(23 + wsel)});
            for (int i = n - 1; i >= 0; i--)
                burst.push_back(len[8*i +: 8]);
        end
    endtask

    function automatic logic [63:0] any_length();
        logic [63:0] r;
        case ($urandom_range(0, 5))
            0: r = 64'($urandom_range(0, 23));
            1: r = 64'($urandom_range(24, 255));
            2: r = 64'($urandom_range(256, 65535));
            3: r = {32'd0, $urandom} | 64'h1_0000;
            4: r = {$urandom, $urandom} | 64'h1_0000_0000;
            default:
            begin
                case ($urandom_range(0, 5))
                    0: r = 64'd24;
                    1: r = 64'd256;
                    2: r = 64'h1_0000;
                    3: r = 64'hFFFF_FFFF;
                    4: r = 64'h1_0000_0000;
                    default: r = 64'hFFFF_FFFF_FFFF_FFFF;
                endcase
            end
        endcase
        return r;
    endfunction

    function automatic logic [63:0] float_bits();
        logic [63:0] r;
        case ($urandom_range(0, 7))
            0: r = CANON_NAN;
            1: r = {1'($urandom_range(0, 1)), 11'h7FF, 52'd0};
            2: r = {1'($urandom_range(0, 1)), 11'h7FF, 20'($urandom), $urandom} | 64'd1;
            3: r = 64'hFFF8_0000_0000_0000;
            4: r = 64'h7FF0_0000_0000_0001;
            5: r = {$urandom_range(0, 1) ? 64'd0 : 64'hFFFF_FFFF_FFFF_FFFF};
            default: r = {$urandom, $urandom};
        endcase
        return r;
    endfunction

    // One character of UTF-8, mostly well formed, with the boundary sequences.
    task automatic push_glyph();
        logic [7:0] lead;
        case ($urandom_range(0, 7))
            0, 1, 2: glyphs.push_back(8'($urandom_range(0, 127)));
            3:
            begin
                glyphs.push_back(8'($urandom_range(8'hC2, 8'hDF)));
                glyphs.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            4:
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        glyphs.push_back(8'hE0);
                        glyphs.push_back(8'($urandom_range(8'hA0, 8'hBF)));
                    end
                    1:
                    begin
                        glyphs.push_back(8'hED);
                        glyphs.push_back(8'($urandom_range(8'h80, 8'h9F)));
                    end
                    default:
                    begin
                        lead = 8'($urandom_range(8'hE1, 8'hEF));
                        glyphs.push_back(lead == 8'hED ? 8'hEE : lead);
                        glyphs.push_back(8'($urandom_range(8'h80, 8'hBF)));
                    end
                endcase
                glyphs.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            5:
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        glyphs.push_back(8'hF0);
                        glyphs.push_back(8'($urandom_range(8'h90, 8'hBF)));
                    end
                    1:
                    begin
                        glyphs.push_back(8'($urandom_range(8'hF1, 8'hF3)));
                        glyphs.push_back(8'($urandom_range(8'h80, 8'hBF)));
                    end
                    default:
                    begin
                        glyphs.push_back(8'hF4);
                        glyphs.push_back(8'($urandom_range(8'h80, 8'h8F)));
                    end
                endcase
                glyphs.push_back(8'($urandom_range(8'h80, 8'hBF)));
                glyphs.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            6:
            begin
                // Edges of the valid ranges.
                case ($urandom_range(0, 3))
                    0: begin glyphs.push_back(8'hC2); glyphs.push_back(8'h80); end
                    1: begin glyphs.push_back(8'hDF); glyphs.push_back(8'hBF); end
                    2:
                    begin
                        glyphs.push_back(8'hEF);
                        glyphs.push_back(8'hBF);
                        glyphs.push_back(8'hBF);
                    end
                    default:
                    begin
                        glyphs.push_back(8'hF4);
                        glyphs.push_back(8'h8F);
                        glyphs.push_back(8'hBF);
                        glyphs.push_back(8'hBF);
                    end
                endcase
            end
            default: glyphs.push_back($urandom_range(0, 1) ? 8'h7F : 8'h00);
        endcase
    endtask

    // Text or byte string: head then payload, sometimes spoilt.
    task automatic push_string(input logic [2:0] major, input bit skew);
        int n;
        glyphs.delete();
        if (major == MAJOR_TEXT)
        begin
            n = $urandom_range(0, 10);
            repeat (n) push_glyph();
            if ($urandom_range(0, 4) == 0 && glyphs.size() > 0)
                glyphs[$urandom_range(0, glyphs.size() - 1)] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 9) == 0 && glyphs.size() > 0)
                void'(glyphs.pop_back());
        end
        else
        begin
            n = $urandom_range(0, 3) == 0 ? $urandom_range(24, 40) : $urandom_range(0, 12);
            repeat (n) glyphs.push_back(8'($urandom_range(0, 255)));
        end
        push_head(major, 64'(glyphs.size()), skew);
        foreach (glyphs[i])
            burst.push_back(glyphs[i]);
    endtask

    // One random item appended to the current buffer.
    task automatic push_item();
        int pick;
        logic [63:0] f;
        logic [2:0] odd_major [0:3];
        odd_major = '{3'd0, 3'd1, 3'd6, 3'd7};
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            case ($urandom_range(0, 2))
                0: burst.push_back(BYTE_NULL);
                1: burst.push_back(BYTE_TRUE);
                default: burst.push_back(BYTE_FALSE);
            endcase
        end
        else if (pick < 20)
        begin
            f = float_bits();
            burst.push_back(BYTE_FLOAT);
            for (int i = 7; i >= 0; i--)
                burst.push_back(f[8*i +: 8]);
        end
        else if (pick < 36)
            push_string(MAJOR_TEXT, 1'b0);
        else if (pick < 48)
            push_string(MAJOR_BYTES, 1'b0);
        else if (pick < 62)
            push_head($urandom_range(0, 1) ? MAJOR_ARRAY : MAJOR_MAP, any_length(), 1'b0);
        else if (pick < 70)
            push_head(3'($urandom_range(2, 5)), any_length(), 1'b1);
        else if (pick < 75)
            push_head(odd_major[$urandom_range(0, 3)], any_length(), 1'($urandom_range(0, 1)));
        else if (pick < 80)
            burst.push_back({3'($urandom_range(0, 7)), 5'($urandom_range(28, 31))});
        else if (pick < 92)
            burst.push_back(8'($urandom_range(0, 255)));
        else
        begin
            // Long string head; its payload swallows what follows or is cut short.
            push_head($urandom_range(0, 1) ? MAJOR_TEXT : MAJOR_BYTES,
                      any_length() | 64'd24, 1'b0);
            repeat ($urandom_range(0, 6))
                burst.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin : stimulus
        int nitems;
        int cut;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed script.
        for (int i = 0; i < SCRIPT_LEN; i++)
            put_word(SCRIPT[i].b, SCRIPT[i].eoi, SCRIPT[i].typed, SCRIPT[i].gives,
                     SCRIPT[i].w);
        drain_decoder();

        // Random buffers of items; the last byte of each carries end of input.
        while (live_words < 1200)
        begin
            calm = ($urandom_range(0, 7) == 0);
            burst.delete();
            nitems = $urandom_range(1, 6);
            repeat (nitems) push_item();
            if ($urandom_range(0, 5) == 0 && burst.size() > 1)
            begin
                cut = $urandom_range(1, burst.size() - 1);
                repeat (cut) void'(burst.pop_back());
            end
            for (int i = 0; i < burst.size(); i++)
                put_word(burst[i], i == burst.size() - 1, 1'b0, 1'b0, W_NONE);
            if ($urandom_range(0, 19) == 0)
                drain_decoder();
        end
        drain_decoder();
        repeat (16) @(posedge clk);

        if (faults == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
